// ===== rtl/pit_pkg.sv =====
// Package for the periodic interrupt timer device: register offsets, item codes,
// and the structures passed between the top level and the timer core.
// Has no dependencies.
package pit_pkg;

    localparam logic [11:0] OFF_CONFIG = 12'h004;
    localparam logic [11:0] OFF_STATUS = 12'h008;
    localparam int unsigned ACK_BIT = 18;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] SIZE_4 = 2'd0;
    localparam logic [1:0] SIZE_8 = 2'd1;

    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 72;

    typedef struct packed {
        logic [1:0]  action;
        logic [11:0] offset;
        logic [1:0]  access_size;
        logic [63:0] write_data;
    } pit_item_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        irq_level;
    } pit_result_t;

    typedef struct packed {
        logic armed;
        logic remaining_nz;
    } pit_timer_status_t;

endpackage

// ===== rtl/pit_core.sv =====
// Timer core: holds the device state and computes one item's result and update.
// Depends on pit_pkg.
module pit_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  pit_pkg::pit_item_t         item,
    output pit_pkg::pit_result_t       result,
    output pit_pkg::pit_timer_status_t timer_status
);
    import pit_pkg::*;

    logic [31:0] config_reg,    config_next;
    logic        ready_reg,     ready_next;
    logic [15:0] count_reg,     count_next;
    logic        pending_reg,   pending_next;
    logic [31:0] stamp_reg,     stamp_next;
    logic [31:0] time_reg,      time_next;
    logic [30:0] remaining_reg, remaining_next;
    logic        armed_reg,     armed_next;

    logic [63:0] status_value;
    logic [63:0] reg_value;
    logic [63:0] wr_value;
    logic [63:0] rd_value;
    logic [31:0] rearm_cfg;

    assign status_value = {1'b0, stamp_reg, 12'd0, pending_reg, count_reg, 1'b0, ready_reg};

    always_comb
    begin
        reg_value = 64'd0;
        if (item.offset == OFF_CONFIG)
        begin
            reg_value = {32'd0, config_reg};
        end
        else if (item.offset == OFF_STATUS)
        begin
            reg_value = status_value;
        end

        unique case (item.access_size)
            SIZE_4:  rd_value = {32'd0, reg_value[31:0]};
            SIZE_8:  rd_value = reg_value;
            default: rd_value = 64'd0;
        endcase

        unique case (item.access_size)
            SIZE_4:  wr_value = {32'd0, item.write_data[31:0]};
            SIZE_8:  wr_value = item.write_data;
            default: wr_value = 64'd0;
        endcase
    end

    always_comb
    begin
        config_next    = config_reg;
        ready_next     = ready_reg;
        count_next     = count_reg;
        pending_next   = pending_reg;
        stamp_next     = stamp_reg;
        time_next      = time_reg;
        remaining_next = remaining_reg;
        armed_next     = armed_reg;
        rearm_cfg      = config_reg;

        unique case (item.action)
            ACT_WRITE:
            begin
                if (item.offset == OFF_CONFIG)
                begin
                    config_next = wr_value[31:0];
                    rearm_cfg   = wr_value[31:0];
                    if (wr_value[0])
                    begin
                        ready_next = 1'b1;
                    end
                    if (rearm_cfg[0] && (rearm_cfg[31:1] != 31'd0))
                    begin
                        remaining_next = rearm_cfg[31:1];
                        armed_next     = 1'b1;
                    end
                    else
                    begin
                        remaining_next = 31'd0;
                        armed_next     = 1'b0;
                    end
                end
                else if (item.offset == OFF_STATUS)
                begin
                    if (wr_value[ACK_BIT])
                    begin
                        pending_next = 1'b0;
                    end
                end
            end
            ACT_TICK:
            begin
                time_next = time_reg + 32'd1;
                if (armed_reg)
                begin
                    if (remaining_reg <= 31'd1)
                    begin
                        stamp_next   = time_next;
                        count_next   = count_reg + 16'd1;
                        pending_next = 1'b1;
                        if (rearm_cfg[0] && (rearm_cfg[31:1] != 31'd0))
                        begin
                            remaining_next = rearm_cfg[31:1];
                            armed_next     = 1'b1;
                        end
                        else
                        begin
                            remaining_next = 31'd0;
                            armed_next     = 1'b0;
                        end
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 31'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            config_reg    <= 32'd0;
            ready_reg     <= 1'b0;
            count_reg     <= 16'd0;
            pending_reg   <= 1'b0;
            stamp_reg     <= 32'd0;
            time_reg      <= 32'd0;
            remaining_reg <= 31'd0;
            armed_reg     <= 1'b0;
        end
        else if (step)
        begin
            config_reg    <= config_next;
            ready_reg     <= ready_next;
            count_reg     <= count_next;
            pending_reg   <= pending_next;
            stamp_reg     <= stamp_next;
            time_reg      <= time_next;
            remaining_reg <= remaining_next;
            armed_reg     <= armed_next;
        end
    end

    assign result.read_data = (item.action == ACT_READ) ? rd_value : 64'd0;
    assign result.irq_level = pending_next;

    assign timer_status.armed        = armed_reg;
    assign timer_status.remaining_nz = (remaining_reg != 31'd0);

endmodule

// ===== rtl/periodic_interrupt_timer_device_top.sv =====
// Path: input stage register, timer core, then output register for the result.
// Throughput: one beat per cycle (one core update pass each) unless output stalls.
// Reset: rst_n clears all device state to zero and empties both stages.
// Top level of the periodic interrupt timer device: input stage, timer core
// and output register. Depends on pit_pkg and pit_core.
module periodic_interrupt_timer_device_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // offset [11:0], access_size [13:12], write_data [77:14], zero [79:78]
    input  logic [pit_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // action [1:0]
    input  logic [pit_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // read_data [63:0], irq_level [64], zero [71:65]
    output logic [pit_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import pit_pkg::*;

    logic              in_valid_reg;
    pit_item_t         in_item_reg;
    logic              out_valid_reg;
    pit_result_t       out_result_reg;
    logic              advance;
    pit_result_t       core_result;
    pit_timer_status_t timer_status;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.action      <= s_axis_tuser;
            in_item_reg.offset      <= s_axis_tdata[11:0];
            in_item_reg.access_size <= s_axis_tdata[13:12];
            in_item_reg.write_data  <= s_axis_tdata[77:14];
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    pit_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (in_item_reg),
        .result       (core_result),
        .timer_status (timer_status)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_result_reg.irq_level, out_result_reg.read_data};

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("Input stage empty but not ready.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("Held beat lost from the input stage.");

    assert property (@(posedge clk) disable iff (!rst_n)
        timer_status.armed |-> timer_status.remaining_nz)
        else $error("Countdown armed with nothing remaining.");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_axis_tvalid)
        else $error("Processed beat did not reach the output register.");

endmodule

// ===== sim/pit_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the periodic interrupt timer device: predicts the result beat of
// every accepted input beat and compares it with the beats leaving the block.
// Depends on pit_pkg.
module pit_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [pit_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [pit_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [pit_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output int                               mismatches,
    output int                               awaited
);
    import pit_pkg::*;

    logic [31:0] cfg_word;
    logic        ready_bit;
    logic [15:0] fire_count;
    logic        pending_bit;
    logic [31:0] fire_stamp;
    logic [31:0] now_us;
    logic [30:0] countdown;
    logic        running;
    int          failures;

    pit_result_t expected_beats[$];

    task automatic reload_countdown();
        if (cfg_word[0] && cfg_word[31:1] != '0)
        begin
            countdown = cfg_word[31:1];
            running = 1'b1;
        end
        else
        begin
            countdown = '0;
            running = 1'b0;
        end
    endtask

    task automatic predict_timer_beat(input pit_item_t item, output pit_result_t res);
        logic [63:0] value;
        value = '0;
        res.read_data = '0;
        case (item.action)
            ACT_READ:
            begin
                if (item.offset == OFF_CONFIG)
                    value = {32'b0, cfg_word};
                else if (item.offset == OFF_STATUS)
                    value = {1'b0, fire_stamp, 12'b0, pending_bit, fire_count, 1'b0, ready_bit};
                if (item.access_size == SIZE_4)
                    res.read_data = {32'b0, value[31:0]};
                else if (item.access_size == SIZE_8)
                    res.read_data = value;
            end
            ACT_WRITE:
            begin
                if (item.access_size == SIZE_4)
                    value = {32'b0, item.write_data[31:0]};
                else if (item.access_size == SIZE_8)
                    value = item.write_data;
                if (item.offset == OFF_CONFIG)
                begin
                    cfg_word = value[31:0];
                    if (cfg_word[0])
                        ready_bit = 1'b1;
                    reload_countdown();
                end
                else if (item.offset == OFF_STATUS)
                begin
                    if (value[ACK_BIT])
                        pending_bit = 1'b0;
                end
            end
            ACT_TICK:
            begin
                now_us = now_us + 32'd1;
                if (running)
                begin
                    if (countdown <= 31'd1)
                    begin
                        fire_stamp = now_us;
                        fire_count = fire_count + 16'd1;
                        pending_bit = 1'b1;
                        reload_countdown();
                    end
                    else
                        countdown = countdown - 31'd1;
                end
            end
            default:
            begin
            end
        endcase
        res.irq_level = pending_bit;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pit_item_t   item;
        pit_result_t want;
        pit_result_t got;
        if (!rst_n)
        begin
            cfg_word = '0;
            ready_bit = 1'b0;
            fire_count = '0;
            pending_bit = 1'b0;
            fire_stamp = '0;
            now_us = '0;
            countdown = '0;
            running = 1'b0;
            failures = 0;
            expected_beats.delete();
            mismatches <= 0;
            awaited <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.read_data = m_axis_tdata[63:0];
                got.irq_level = m_axis_tdata[64];
                if (expected_beats.size() == 0)
                begin
                    if (failures < 10)
                        $display("%0t: result beat with none expected: read_data %h irq %b",
                                 $realtime, got.read_data, got.irq_level);
                    failures++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got.read_data !== want.read_data || got.irq_level !== want.irq_level)
                    begin
                        if (failures < 10)
                            $display({"%0t: mismatch: read_data %h (expected %h), ",
                                      "irq %b (expected %b)"},
                                     $realtime, got.read_data, want.read_data,
                                     got.irq_level, want.irq_level);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                item.action = s_axis_tuser;
                item.offset = s_axis_tdata[11:0];
                item.access_size = s_axis_tdata[13:12];
                item.write_data = s_axis_tdata[77:14];
                predict_timer_beat(item, want);
                expected_beats.push_back(want);
            end
            mismatches <= failures;
            awaited <= expected_beats.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the periodic interrupt timer device: drives bus accesses and ticks,
// throttles the result side and gives the verdict. Depends on pit_pkg, the device top
// and pit_checker.
module tb;
    import pit_pkg::*;

    localparam logic [1:0] ACT_NONE   = 2'd3;
    localparam logic [1:0] SIZE_OTHER = 2'd2;
    localparam logic [1:0] SIZE_SPARE = 2'd3;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int LONG_HOLD      = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]   s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    int                      mismatches;
    int                      awaited;
    int                      sent_items = 0;

    always #4 clk = ~clk;

    periodic_interrupt_timer_device_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pit_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .awaited       (awaited)
    );

    task automatic issue_bus_item(input logic [1:0] act, input logic [11:0] off,
                                  input logic [1:0] sz, input logic [63:0] wd);
        int gap;
        gap = ((sent_items % 200) >= 160) ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {2'b00, wd, sz, off};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_items++;
    endtask

    task automatic run_ticks(input int count);
        repeat (count) issue_bus_item(ACT_TICK, 12'($urandom_range(0, 4095)),
                                      2'($urandom_range(0, 3)), {$urandom, $urandom});
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    initial
    begin : receiver
        int hold;
        int taken;
        taken = 0;
        forever
        begin
            if (taken == 400)
                hold = LONG_HOLD;
            else if ((taken % 250) >= 200)
                hold = 0;
            else
                hold = $urandom_range(0, 3);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            taken++;
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int          kind;
        int          burst;
        int          pick;
        logic [30:0] interval;
        logic [63:0] data;
        logic [1:0]  sz;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_bus_item(ACT_READ, OFF_CONFIG, SIZE_4, '0);
        issue_bus_item(ACT_READ, OFF_STATUS, SIZE_8, '0);
        issue_bus_item(ACT_WRITE, OFF_CONFIG, SIZE_4, {32'hFFFF_FFFF, 32'h0000_0007});
        run_ticks(3);
        issue_bus_item(ACT_READ, OFF_STATUS, SIZE_4, '0);
        issue_bus_item(ACT_READ, OFF_STATUS, SIZE_8, '0);
        run_ticks(3);
        issue_bus_item(ACT_WRITE, OFF_STATUS, SIZE_8, ~(64'd1 << ACK_BIT));
        issue_bus_item(ACT_WRITE, OFF_STATUS, SIZE_8, 64'd1 << ACK_BIT);
        issue_bus_item(ACT_READ, OFF_CONFIG, SIZE_OTHER, '0);
        issue_bus_item(ACT_WRITE, OFF_CONFIG, SIZE_OTHER, '1);
        run_ticks(1);
        issue_bus_item(ACT_WRITE, OFF_CONFIG, SIZE_4, 64'd1);
        run_ticks(1);
        issue_bus_item(ACT_WRITE, OFF_CONFIG, SIZE_8, {32'hA5A5_5A5A, 32'hFFFF_FFFF});
        issue_bus_item(ACT_READ, OFF_CONFIG, SIZE_8, '0);
        issue_bus_item(ACT_NONE, OFF_STATUS, SIZE_8, '1);
        issue_bus_item(ACT_READ, 12'hFFF, SIZE_8, '0);
        issue_bus_item(ACT_WRITE, 12'h005, SIZE_4, '1);
        issue_bus_item(ACT_WRITE, OFF_CONFIG, SIZE_4, 64'd10);
        issue_bus_item(ACT_READ, OFF_STATUS, SIZE_SPARE, '0);
        issue_bus_item(ACT_WRITE, OFF_STATUS, SIZE_4, 64'd1 << ACK_BIT);

        // Hold the sender back until the block has returned every result.
        drain_results();

        burst = sent_items + RANDOM_ITEMS;
        while (sent_items < burst)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 12)
            begin
                interval = ($urandom_range(0, 9) == 0) ? 31'($urandom_range(13, 60))
                                                       : 31'($urandom_range(1, 12));
                sz = $urandom_range(0, 1) ? SIZE_8 : SIZE_4;
                issue_bus_item(ACT_WRITE, OFF_CONFIG, sz, {$urandom, interval, 1'b1});
                repeat ($urandom_range(4, 40))
                begin
                    pick = $urandom_range(0, 19);
                    sz = $urandom_range(0, 1) ? SIZE_8 : SIZE_4;
                    if (pick < 13)
                        run_ticks(1);
                    else if (pick < 16)
                        issue_bus_item(ACT_READ, OFF_STATUS, sz, {$urandom, $urandom});
                    else if (pick < 18)
                    begin
                        data = {$urandom, $urandom};
                        if ($urandom_range(0, 2) != 0)
                            data[ACK_BIT] = 1'b1;
                        issue_bus_item(ACT_WRITE, OFF_STATUS, sz, data);
                    end
                    else if (pick == 18)
                        issue_bus_item(ACT_READ, OFF_CONFIG, sz, '0);
                    else
                        issue_bus_item(ACT_READ, 12'($urandom_range(0, 4095)), sz, '0);
                end
            end
            else if (kind < 17)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    pick = $urandom_range(0, 2);
                    issue_bus_item(2'($urandom_range(0, 3)),
                                   (pick == 0) ? OFF_CONFIG :
                                   (pick == 1) ? OFF_STATUS : 12'($urandom_range(0, 4095)),
                                   2'($urandom_range(0, 3)), {$urandom, $urandom});
                end
            end
            else
            begin
                pick = $urandom_range(0, 2);
                data = {$urandom, $urandom};
                if (pick == 0)
                    data[0] = 1'b0;
                else if (pick == 1)
                    data[31:1] = '0;
                sz = (pick == 2) ? 2'($urandom_range(SIZE_OTHER, SIZE_SPARE))
                                 : ($urandom_range(0, 1) ? SIZE_8 : SIZE_4);
                issue_bus_item(ACT_WRITE, OFF_CONFIG, sz, data);
                run_ticks($urandom_range(1, 8));
            end
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && awaited == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
